/* rtl/pwfd_pkg.sv */
`timescale 1ns / 1ps
package pwfd_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int FRAME_BITS   = SENSOR_COUNT * 8 + 1;
    localparam int FRAME_W      = SENSOR_COUNT * 8;
    localparam int IDX_W        = 3;
    localparam int CNT_W        = 7;
    localparam int PW_W         = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int STATUS_W     = 2;
    localparam int DIST_W       = 8;

    localparam logic [CNT_W-1:0] MAX_ATTEMPTS_RST = CNT_W'(65);
    localparam logic [CNT_W-1:0] FRAME_BITS_C     = CNT_W'(FRAME_BITS);

    localparam logic [CFG_ADDR_W-1:0] REG_START_MIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_MAX    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MAX      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MIN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MAX     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS = 3'd6;

    localparam logic [STATUS_W-1:0] ST_READING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd2;

    typedef enum logic [1:0] {
        JOB_NO_DATA,
        JOB_SHORT,
        JOB_FRAME
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [FRAME_W-1:0] bits;
    } t_job;

    // sensors 1/3 and 5/7 trade places
    function automatic logic [IDX_W-1:0] src_sensor(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] s;
        unique case (k)
            3'd1:    s = 3'd3;
            3'd3:    s = 3'd1;
            3'd5:    s = 3'd7;
            3'd7:    s = 3'd5;
            default: s = k;
        endcase
        return s;
    endfunction

endpackage

/* rtl/pwfd_front.sv */
`timescale 1ns / 1ps
module pwfd_front import pwfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PW_W-1:0]       i_cfg_wr_data,
    input  logic                  i_push,
    input  logic [PW_W-1:0]       i_pulse_width,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    logic [PW_W-1:0]    r_start_min, r_start_max, r_one_min, r_one_max;
    logic [PW_W-1:0]    r_zero_min, r_zero_max;
    logic [CNT_W-1:0]   r_max_att;
    logic               r_in_frame, n_in_frame;
    logic [CNT_W-1:0]   r_hunt, n_hunt;
    logic [CNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [FRAME_W-1:0] r_bits, n_bits;
    logic               is_start, is_one, is_zero, fire, emit;
    t_kind              kind;

    assign o_full = i_q_full;
    assign fire   = i_push && !i_q_full;

    assign is_start = (i_pulse_width >= r_start_min) && (i_pulse_width <= r_start_max);
    assign is_one   = (i_pulse_width >= r_one_min) && (i_pulse_width <= r_one_max);
    assign is_zero  = (i_pulse_width >= r_zero_min) && (i_pulse_width <= r_zero_max);

    always_comb begin
        n_in_frame = r_in_frame;
        n_hunt     = r_hunt;
        n_bit_cnt  = r_bit_cnt;
        n_bits     = r_bits;
        emit       = 1'b0;
        kind       = JOB_NO_DATA;
        if (!r_in_frame) begin
            if (r_hunt >= r_max_att) begin
                n_hunt = '0;
                emit   = 1'b1;
            end else if (is_start) begin
                n_in_frame = 1'b1;
                n_hunt     = '0;
                n_bit_cnt  = '0;
                n_bits     = '0;
            end else begin
                n_hunt = r_hunt + CNT_W'(1);
            end
        end else if (!is_start) begin
            if ((is_one || is_zero) && (r_bit_cnt < FRAME_BITS_C)) begin
                if (r_bit_cnt != '0) begin
                    n_bits = {r_bits[FRAME_W-2:0], is_one};
                end
                n_bit_cnt = r_bit_cnt + CNT_W'(1);
            end
        end else begin
            n_in_frame = 1'b0;
            n_hunt     = '0;
            emit       = 1'b1;
            priority if (r_bit_cnt <= CNT_W'(1)) begin
                kind = JOB_NO_DATA;
            end else if (r_bit_cnt < FRAME_BITS_C) begin
                kind = JOB_SHORT;
            end else begin
                kind = JOB_FRAME;
            end
        end
    end

    assign o_q_push      = fire && emit;
    assign o_q_job.kind  = kind;
    assign o_q_job.bits  = r_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_min <= '0;
            r_start_max <= '0;
            r_one_min   <= '0;
            r_one_max   <= '0;
            r_zero_min  <= '0;
            r_zero_max  <= '0;
            r_max_att   <= MAX_ATTEMPTS_RST;
            r_in_frame  <= 1'b0;
            r_hunt      <= '0;
            r_bit_cnt   <= '0;
            r_bits      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_START_MIN:    r_start_min <= i_cfg_wr_data;
                    REG_START_MAX:    r_start_max <= i_cfg_wr_data;
                    REG_ONE_MIN:      r_one_min   <= i_cfg_wr_data;
                    REG_ONE_MAX:      r_one_max   <= i_cfg_wr_data;
                    REG_ZERO_MIN:     r_zero_min  <= i_cfg_wr_data;
                    REG_ZERO_MAX:     r_zero_max  <= i_cfg_wr_data;
                    REG_MAX_ATTEMPTS: r_max_att   <= i_cfg_wr_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_in_frame <= n_in_frame;
                r_hunt     <= n_hunt;
                r_bit_cnt  <= n_bit_cnt;
                r_bits     <= n_bits;
            end
        end
    end

endmodule

/* rtl/pwfd_queue.sv */
`timescale 1ns / 1ps
module pwfd_queue import pwfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job        r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

/* rtl/pwfd_back.sv */
`timescale 1ns / 1ps
module pwfd_back import pwfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_job                i_q_job,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_sensor_index,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_last
);

    logic             r_valid;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             is_frame, beat, load;
    logic [IDX_W-1:0] src, byte_sel;

    assign is_frame = (r_job.kind == JOB_FRAME);
    assign beat     = r_valid && i_pop;
    assign load     = !r_valid || (beat && o_last);
    assign o_q_pop  = load;

    assign o_empty = !r_valid;
    assign o_last  = !is_frame || (r_idx == IDX_W'(SENSOR_COUNT - 1));
    assign src      = src_sensor(r_idx);
    assign byte_sel = IDX_W'(SENSOR_COUNT - 1) - src;

    always_comb begin
        unique case (r_job.kind)
            JOB_FRAME: o_status = ST_READING;
            JOB_SHORT: o_status = ST_SHORT;
            default:   o_status = ST_NO_DATA;
        endcase
    end

    assign o_sensor_index = is_frame ? r_idx : '0;
    assign o_distance     = is_frame ? r_job.bits[byte_sel*DIST_W +: DIST_W] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            r_idx   <= '0;
        end else if (beat) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

endmodule

/* rtl/pulse_width_frame_decoder.sv */
`timescale 1ns / 1ps
// The first result beat of a frame-closing pulse passes through the job queue and the drain's result register.
// Throughput: one pulse per cycle; a full frame drains as eight beats, one per cycle while pop is held.
// push stalls only while the two-entry job queue between classifier and drain is full.
// Reset: synchronous active low; thresholds clear to 0, max_attempts to 65,
// decoder returns to hunting and all pending results are dropped.
module pulse_width_frame_decoder import pwfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PW_W-1:0]       i_cfg_wr_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [PW_W-1:0]       i_pulse_width,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]      o_sensor_index,
    output logic [DIST_W-1:0]     o_distance,
    output logic                  o_last
);

    logic q_push, q_full, q_pop, q_valid;
    t_job q_in, q_out;

    pwfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (i_push),
        .i_pulse_width (i_pulse_width),
        .i_q_full      (q_full),
        .o_full        (o_full),
        .o_q_push      (q_push),
        .o_q_job       (q_in)
    );

    pwfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out)
    );

    pwfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (q_out),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_status       (o_status),
        .o_sensor_index (o_sensor_index),
        .o_distance     (o_distance),
        .o_last         (o_last)
    );

`ifndef NO_ASSERTIONS
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status == ST_READING || o_status == ST_NO_DATA
                      || o_status == ST_SHORT))
        else $error("illegal status on result");

    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != ST_READING) |-> (o_sensor_index == '0
                                                  && o_distance == '0 && o_last))
        else $error("error result carries payload or is not last");

    a_reading_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_status == ST_READING && !o_last) |=>
            (!o_empty && o_status == ST_READING
             && o_sensor_index == $past(o_sensor_index) + IDX_W'(1)))
        else $error("sensor readings out of order");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not empty after reset");
`endif

endmodule

/* tb/pulse_width_frame_decoder_tb.sv */
`timescale 1ns / 1ps
module pulse_width_frame_decoder_tb;
    import pwfd_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    idx;
        logic [DIST_W-1:0]   distance;
        logic                last;
    } t_beat;

    // one directed row: a register write or a pulse, with an optional hand-typed beat
    typedef struct packed {
        logic                  wr;
        logic [CFG_ADDR_W-1:0] addr;
        logic [PW_W-1:0]       val;
        logic                  typed;
        logic [STATUS_W-1:0]   st;
    } t_step;

    localparam int N_DIRECTED    = 24;
    localparam int HOLD_CYCLES   = 1000;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [PW_W-1:0]       i_cfg_wr_data;
    logic                  i_push;
    logic                  o_full;
    logic [PW_W-1:0]       i_pulse_width;
    logic                  o_empty;
    logic                  i_pop;
    logic [STATUS_W-1:0]   o_status;
    logic [IDX_W-1:0]      o_sensor_index;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_last;

    pulse_width_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_pulse_width  (i_pulse_width),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_status       (o_status),
        .o_sensor_index (o_sensor_index),
        .o_distance     (o_distance),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder mirror
    logic [PW_W-1:0]    thr [0:5];
    logic [CNT_W-1:0]   max_tries;
    logic               in_frame;
    logic [CNT_W-1:0]   hunt_cnt;
    logic [CNT_W-1:0]   bit_cnt;
    logic [FRAME_W-1:0] frame_reg;

    t_beat  exp_beats [$];
    t_step  directed_steps [N_DIRECTED];
    int     errors = 0;
    int     pulses_sent = 0;
    int     burst_left = 0;
    bit     hold_req = 1'b0;

    function automatic bit in_win(input logic [PW_W-1:0] w, input logic [PW_W-1:0] lo,
                                  input logic [PW_W-1:0] hi);
        return (w >= lo) && (w <= hi);
    endfunction

    // advances the mirror by one pulse, queues the beats it causes
    function automatic int decode_pulse(input logic [PW_W-1:0] w);
        logic              is_start;
        logic              b;
        logic [DIST_W-1:0] d [SENSOR_COUNT];
        logic [DIST_W-1:0] t;
        int                n;
        is_start = in_win(w, thr[REG_START_MIN], thr[REG_START_MAX]);
        n = 0;
        pulses_sent++;
        if (!in_frame) begin
            if (hunt_cnt >= max_tries) begin
                hunt_cnt = '0;
                exp_beats.push_back(t_beat'{ST_NO_DATA, '0, '0, 1'b1});
                n = 1;
            end else begin
                hunt_cnt = hunt_cnt + 1'b1;
                if (is_start) begin
                    in_frame  = 1'b1;
                    hunt_cnt  = '0;
                    bit_cnt   = '0;
                    frame_reg = '0;
                end
            end
        end else if (!is_start) begin
            if (in_win(w, thr[REG_ONE_MIN], thr[REG_ONE_MAX]) ||
                in_win(w, thr[REG_ZERO_MIN], thr[REG_ZERO_MAX])) begin
                b = in_win(w, thr[REG_ONE_MIN], thr[REG_ONE_MAX]);
                if (bit_cnt < FRAME_BITS_C) begin
                    if (bit_cnt != 0)
                        frame_reg = {frame_reg[FRAME_W-2:0], b};
                    bit_cnt = bit_cnt + 1'b1;
                end
            end
        end else begin
            in_frame = 1'b0;
            hunt_cnt = '0;
            if (bit_cnt <= 1) begin
                exp_beats.push_back(t_beat'{ST_NO_DATA, '0, '0, 1'b1});
                n = 1;
            end else if (bit_cnt < FRAME_BITS_C) begin
                exp_beats.push_back(t_beat'{ST_SHORT, '0, '0, 1'b1});
                n = 1;
            end else begin
                for (int k = 0; k < SENSOR_COUNT; k++)
                    d[k] = frame_reg[FRAME_W-1-8*k -: 8];
                t = d[1]; d[1] = d[3]; d[3] = t;
                t = d[5]; d[5] = d[7]; d[7] = t;
                for (int k = 0; k < SENSOR_COUNT; k++)
                    exp_beats.push_back(t_beat'{ST_READING, IDX_W'(k), d[k],
                                                k == SENSOR_COUNT - 1});
                n = SENSOR_COUNT;
            end
        end
        return n;
    endfunction

    function automatic logic [PW_W-1:0] pick_in(input logic [PW_W-1:0] lo,
                                                input logic [PW_W-1:0] hi);
        if (lo <= hi)
            return PW_W'($urandom_range(hi, lo));
        return PW_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [PW_W-1:0] pick_off_start();
        logic [PW_W-1:0] lo;
        logic [PW_W-1:0] hi;
        lo = thr[REG_START_MIN];
        hi = thr[REG_START_MAX];
        if (lo > hi || (lo == 0 && hi == 16'hFFFF))
            return PW_W'($urandom_range(0, 16'hFFFF));
        if (hi != 16'hFFFF && (lo == 0 || $urandom_range(0, 1) == 1))
            return PW_W'($urandom_range(16'hFFFF, hi + 1));
        return PW_W'($urandom_range(lo - 1, 0));
    endfunction

    // starts and ends on a falling edge; push stays high into the next call
    task automatic push_pulse(input logic [PW_W-1:0] w, input bit typed,
                              input logic [STATUS_W-1:0] st);
        int n;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        i_push        <= 1'b1;
        i_pulse_width <= w;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        n = decode_pulse(w);
        if (typed) begin
            repeat (n) void'(exp_beats.pop_back());
            exp_beats.push_back(t_beat'{st, '0, '0, 1'b1});
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (exp_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [PW_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= a;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        if (a == REG_MAX_ATTEMPTS)
            max_tries = v[CNT_W-1:0];
        else if (a <= REG_ZERO_MAX)
            thr[a] = v;
    endtask

    task automatic send_frame(input int nbits);
        repeat ($urandom_range(0, 2)) push_pulse(pick_off_start(), 1'b0, ST_READING);
        push_pulse(pick_in(thr[REG_START_MIN], thr[REG_START_MAX]), 1'b0, ST_READING);
        repeat (nbits) begin
            if ($urandom_range(0, 15) == 0)
                push_pulse(PW_W'($urandom), 1'b0, ST_READING);
            if ($urandom_range(0, 1) == 1)
                push_pulse(pick_in(thr[REG_ONE_MIN], thr[REG_ONE_MAX]), 1'b0, ST_READING);
            else
                push_pulse(pick_in(thr[REG_ZERO_MIN], thr[REG_ZERO_MAX]), 1'b0, ST_READING);
        end
        push_pulse(pick_in(thr[REG_START_MIN], thr[REG_START_MAX]), 1'b0, ST_READING);
    endtask

    // result side
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        i_pop     = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       i_pop <= 1'b1;
                    1:       i_pop <= ($urandom_range(0, 1) == 1);
                    default: i_pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (exp_beats.size() == 0) begin
                $error("unexpected beat: status %0d sensor_index %0d distance %0d last %0b",
                       o_status, o_sensor_index, o_distance, o_last);
                errors++;
            end else begin
                e = exp_beats.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_sensor_index !== e.idx) begin
                    $error("sensor_index: expected %0d, got %0d", e.idx, o_sensor_index);
                    errors++;
                end
                if (o_distance !== e.distance) begin
                    $error("distance: expected %0d, got %0d", e.distance, o_distance);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0b, got %0b", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [PW_W-1:0] cfg_val [0:6];
        logic [PW_W-1:0] lo_w [0:2];
        logic [PW_W-1:0] hi_w [0:2];
        bit              cfg_open;
        int              phase;
        int              nseg;
        int              sel;
        int              wid;
        int              rot;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wr_data = '0;
        i_push        = 1'b0;
        i_pulse_width = '0;
        for (int k = 0; k < 6; k++)
            thr[k] = '0;
        max_tries = MAX_ATTEMPTS_RST;
        in_frame  = 1'b0;
        hunt_cnt  = '0;
        bit_cnt   = '0;
        frame_reg = '0;
        cfg_open  = 1'b0;

        directed_steps = '{
            '{1'b0, '0, 16'hFFFF, 1'b0, ST_READING},
            '{1'b0, '0, 16'h0000, 1'b0, ST_READING},
            '{1'b0, '0, 16'h0000, 1'b1, ST_NO_DATA},       // empty frame, reset windows
            '{1'b1, REG_START_MIN, 16'd100, 1'b0, ST_READING},
            '{1'b1, REG_START_MAX, 16'd200, 1'b0, ST_READING},
            '{1'b1, REG_ONE_MIN, 16'd150, 1'b0, ST_READING},
            '{1'b1, REG_ONE_MAX, 16'd400, 1'b0, ST_READING},
            '{1'b1, REG_ZERO_MIN, 16'd300, 1'b0, ST_READING},
            '{1'b1, REG_ZERO_MAX, 16'd600, 1'b0, ST_READING},
            '{1'b1, REG_MAX_ATTEMPTS, 16'hFF82, 1'b0, ST_READING},
            '{1'b0, '0, 16'd50, 1'b0, ST_READING},
            '{1'b0, '0, 16'hFFFF, 1'b0, ST_READING},
            '{1'b0, '0, 16'd7, 1'b1, ST_NO_DATA},          // hunt limit
            '{1'b0, '0, 16'd150, 1'b0, ST_READING},        // start beats one window
            '{1'b0, '0, 16'd350, 1'b0, ST_READING},
            '{1'b0, '0, 16'd1000, 1'b0, ST_READING},       // outside all windows
            '{1'b0, '0, 16'd180, 1'b1, ST_NO_DATA},        // one bit only
            '{1'b0, '0, 16'd100, 1'b0, ST_READING},
            '{1'b0, '0, 16'd500, 1'b0, ST_READING},
            '{1'b0, '0, 16'd300, 1'b0, ST_READING},        // one beats zero window
            '{1'b0, '0, 16'd200, 1'b1, ST_SHORT},
            '{1'b1, REG_MAX_ATTEMPTS, 16'd0, 1'b0, ST_READING},
            '{1'b0, '0, 16'd150, 1'b1, ST_NO_DATA},
            '{1'b0, '0, 16'hFFFF, 1'b1, ST_NO_DATA}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].wr) begin
                if (!cfg_open) begin
                    wait_drained();
                    cfg_open = 1'b1;
                end
                write_reg(directed_steps[i].addr, directed_steps[i].val);
            end else begin
                if (cfg_open) begin
                    i_cfg_wr_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                push_pulse(directed_steps[i].val, directed_steps[i].typed,
                           directed_steps[i].st);
            end
        end

        phase = 0;
        while ((phase < 3 || pulses_sent < 200) && phase < 30) begin
            wait_drained();
            if (phase == 0) begin
                cfg_val[REG_START_MIN]    = 16'd0;
                cfg_val[REG_START_MAX]    = 16'd99;
                cfg_val[REG_ONE_MIN]      = 16'd65000;
                cfg_val[REG_ONE_MAX]      = 16'hFFFF;
                cfg_val[REG_ZERO_MIN]     = 16'd100;
                cfg_val[REG_ZERO_MAX]     = 16'd64999;
                cfg_val[REG_MAX_ATTEMPTS] = 16'd127;
            end else if (phase == 1) begin
                cfg_val[REG_START_MIN]    = 16'hFFFF;
                cfg_val[REG_START_MAX]    = 16'hFFFF;
                cfg_val[REG_ONE_MIN]      = 16'd0;
                cfg_val[REG_ONE_MAX]      = 16'd0;
                cfg_val[REG_ZERO_MIN]     = 16'd1;
                cfg_val[REG_ZERO_MAX]     = 16'hFFFE;
                cfg_val[REG_MAX_ATTEMPTS] = 16'd1;
            end else if (phase >= 3 && $urandom_range(0, 3) == 0) begin
                // overlapping or inverted windows
                for (int k = 0; k < 7; k++)
                    cfg_val[k] = PW_W'($urandom);
                cfg_val[REG_MAX_ATTEMPTS] = PW_W'($urandom_range(0, 127));
            end else begin
                rot = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++) begin
                    wid = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3000);
                    lo_w[k] = PW_W'(((k + rot) % 3) * 21845 + $urandom_range(0, 21844 - wid));
                    hi_w[k] = lo_w[k] + PW_W'(wid);
                end
                cfg_val[REG_START_MIN]    = lo_w[0];
                cfg_val[REG_START_MAX]    = hi_w[0];
                cfg_val[REG_ONE_MIN]      = lo_w[1];
                cfg_val[REG_ONE_MAX]      = hi_w[1];
                cfg_val[REG_ZERO_MIN]     = lo_w[2];
                cfg_val[REG_ZERO_MAX]     = hi_w[2];
                cfg_val[REG_MAX_ATTEMPTS] = PW_W'($urandom_range(0, 127));
            end
            for (int k = REG_START_MIN; k <= REG_MAX_ATTEMPTS; k++)
                write_reg(CFG_ADDR_W'(k), cfg_val[k]);
            i_cfg_wr_en <= 1'b0;

            // long result stall while short jobs keep coming
            if (phase == 2)
                hold_req = 1'b1;
            nseg = (phase == 2) ? 5 : 1;
            repeat (nseg) begin
                if (phase == 2)
                    sel = 8;
                else if (phase == 0)
                    sel = 0;
                else
                    sel = $urandom_range(0, 9);
                if (sel <= 5)
                    send_frame(FRAME_BITS);
                else if (sel == 6)
                    send_frame($urandom_range(FRAME_BITS + 1, FRAME_BITS + 15));
                else if (sel == 7)
                    send_frame($urandom_range(2, FRAME_BITS - 1));
                else if (sel == 8)
                    send_frame($urandom_range(0, 1));
                else begin
                    wid = (int'(max_tries) + 2 < 40) ? int'(max_tries) + 2 : 40;
                    repeat ($urandom_range(1, wid))
                        push_pulse(pick_off_start(), 1'b0, ST_READING);
                end
            end
            phase++;
        end

        wait_drained();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
